>>> src/coset_probability_decoder_core_assert.svh
// Assertion macros for the coset probability decoder core.
// Depends on nothing; included by the top level.
`ifndef COSET_PROBABILITY_DECODER_CORE_ASSERT_SVH
`define COSET_PROBABILITY_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CPD_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define CPD_ASSERT_NXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define CPD_ASSERT_IMP(label, clk, rst, a, c, msg)
`define CPD_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

>>> src/cpd_pkg.sv
// Package for the coset probability decoder: sizes, op codes, register indexes, states.
// Depends on nothing.
`default_nettype none
package cpd_pkg;
   localparam int MaxQubits = 8;
   localparam int MaxClasses = 4;
   localparam int MaxStabilizers = 16;
   localparam int ProbBits = 32;
   localparam int SumBits = 40;
   localparam int QW = 3;
   localparam int CW = 2;
   localparam int SW = 4;
   localparam int SynW = 4;
   localparam int CtAddrW = CW + SW + SynW + QW;

   typedef enum logic [1:0] {
      OP_PROB = 2'd0, OP_CLASS = 2'd1, OP_DECODE = 2'd2, OP_NONE = 2'd3
   } op_type;

   localparam logic [1:0] REG_QUBITS = 2'd0;
   localparam logic [1:0] REG_CLASSES = 2'd1;
   localparam logic [1:0] REG_STABS = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_MUL, ST_ACC, ST_TOT, ST_DIV, ST_DSTEP, ST_DEND, ST_OUT
   } state_type;
endpackage
`default_nettype wire

>>> src/cpd_if.sv
// Valid/ready channel interfaces for the decoder (request, response, register write).
// Depends on nothing.
`default_nettype none
interface cpd_req_if (input wire logic clock);
   logic valid, ready;
   logic [1:0] op;
   logic [2:0] qubit;
   logic [1:0] pauli;
   logic [31:0] prob_value;
   logic [1:0] logical_class;
   logic [3:0] stabilizer;
   logic [3:0] syndrome;
   modport source (output valid, op, qubit, pauli, prob_value, logical_class,
      stabilizer, syndrome, input ready);
   modport sink (input valid, op, qubit, pauli, prob_value, logical_class,
      stabilizer, syndrome, output ready);
endinterface

interface cpd_rsp_if (input wire logic clock);
   logic valid, ready;
   logic [1:0] class_index;
   logic [31:0] class_prob;
   logic [1:0] best_class;
   logic zero_total, last;
   modport source (output valid, class_index, class_prob, best_class, zero_total, last,
      input ready);
   modport sink (input valid, class_index, class_prob, best_class, zero_total, last,
      output ready);
endinterface

interface cpd_csr_if (input wire logic clock);
   logic valid, ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/coset_probability_decoder_core.sv
// Coset probability decoder top level: tables in block memories, one shared multiplier.
// Depends on cpd_pkg, cpd_if and coset_probability_decoder_core_assert.svh.
`default_nettype none
`include "coset_probability_decoder_core_assert.svh"
// Load words are accepted while idle and req_ready stays high for them. A decode word
// is accepted, then walks every class, stabilizer and qubit through the class table
// memory and the probability memory, each qubit in turn through a class read, a
// probability read and a 32x32 multiply and accumulate. The total is then formed. A
// restoring divider then takes each class through a load, 32 steps and a finish, or
// through the load and the finish alone when the total is zero. Results go out one
// per class, each held while rsp_ready is low. One word is worked on at a time;
// req_ready is low during a decode. Tables are undefined until written; no clearing
// pass is run.
module coset_probability_decoder_core (
   input wire logic clock,
   input wire logic reset,
   cpd_req_if.sink req,
   cpd_rsp_if.source rsp,
   cpd_csr_if.sink csr
);
   localparam int QW = cpd_pkg::QW;
   localparam int CW = cpd_pkg::CW;
   localparam int SW = cpd_pkg::SW;
   localparam int PB = cpd_pkg::ProbBits;
   localparam int SB = cpd_pkg::SumBits;

   // memories
   logic [PB-1:0] prob_mem [0:cpd_pkg::MaxQubits*4-1];
   logic [1:0] class_mem [0:(1<<cpd_pkg::CtAddrW)-1];
   logic [PB-1:0] prob_rd;
   logic [1:0] class_rd;
   logic [QW+1:0] prob_raddr;
   logic [cpd_pkg::CtAddrW-1:0] ct_raddr;

   cpd_pkg::state_type state_ff, state_in;
   logic [3:0] nq_ff, nq_in;
   logic [2:0] nc_ff, nc_in;
   logic [4:0] ns_ff, ns_in;
   logic [3:0] syn_ff, syn_in;
   logic [CW-1:0] cls_ff, cls_in;
   logic [SW-1:0] stb_ff, stb_in;
   logic [QW-1:0] qb_ff, qb_in;
   logic [PB-1:0] term_ff, term_in;
   logic [SB-1:0] sums_ff [0:cpd_pkg::MaxClasses-1];
   logic [SB-1:0] sums_in [0:cpd_pkg::MaxClasses-1];
   logic [SB+1:0] tot_ff, tot_in;
   logic [SB+2:0] rem_ff, rem_in;
   logic [PB:0] quo_ff, quo_in;
   logic [5:0] step_ff, step_in;
   logic [PB-1:0] probs_ff [0:cpd_pkg::MaxClasses-1];
   logic [PB-1:0] probs_in [0:cpd_pkg::MaxClasses-1];
   logic [CW-1:0] best_ff, best_in;
   logic rv_ff, rv_in;

   // saturated counts
   logic [3:0] nq_c;
   logic [2:0] nc_c;
   logic [4:0] ns_c;
   always_comb begin
      nq_c = (nq_ff == 4'd0) ? 4'd1 : (nq_ff > 4'(cpd_pkg::MaxQubits)) ?
         4'(cpd_pkg::MaxQubits) : nq_ff;
      nc_c = (nc_ff == 3'd0) ? 3'd1 : (nc_ff > 3'(cpd_pkg::MaxClasses)) ?
         3'(cpd_pkg::MaxClasses) : nc_ff;
      ns_c = (ns_ff == 5'd0) ? 5'd1 : (ns_ff > 5'(cpd_pkg::MaxStabilizers)) ?
         5'(cpd_pkg::MaxStabilizers) : ns_ff;
   end

   logic req_acc;
   assign req.ready = (state_ff == cpd_pkg::ST_IDLE);
   assign req_acc = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // write and read the tables
   always_ff @(posedge clock) begin
      if (req_acc && req.op == cpd_pkg::OP_PROB)
         prob_mem[{req.qubit, req.pauli}] <= req.prob_value;
      if (req_acc && req.op == cpd_pkg::OP_CLASS)
         class_mem[{req.logical_class, req.stabilizer, req.syndrome, req.qubit}] <= req.pauli;
      class_rd <= class_mem[ct_raddr];
      prob_rd <= prob_mem[prob_raddr];
   end
   assign ct_raddr = {cls_ff, stb_ff, syn_ff, qb_ff};
   assign prob_raddr = {qb_ff, class_rd};

   // product, shared by the term chain
   logic [2*PB-1:0] prod;
   assign prod = term_ff * prob_rd;

   logic [SB+2:0] rem_sh;
   logic last_out;
   assign last_out = ({1'b0, cls_ff} + 3'd1 == nc_c);

   always_comb begin
      state_in = state_ff;
      nq_in = nq_ff; nc_in = nc_ff; ns_in = ns_ff; syn_in = syn_ff;
      cls_in = cls_ff; stb_in = stb_ff; qb_in = qb_ff; term_in = term_ff;
      tot_in = tot_ff; rem_in = rem_ff; quo_in = quo_ff; step_in = step_ff;
      best_in = best_ff; rv_in = rv_ff;
      sums_in = sums_ff; probs_in = probs_ff;
      rem_sh = '0;
      if (csr.valid) begin
         case (csr.index)
            cpd_pkg::REG_QUBITS: nq_in = csr.data[3:0];
            cpd_pkg::REG_CLASSES: nc_in = csr.data[2:0];
            cpd_pkg::REG_STABS: ns_in = csr.data[4:0];
            default: ;
         endcase
      end
      case (state_ff)
         cpd_pkg::ST_IDLE: begin
            if (req_acc && req.op == cpd_pkg::OP_DECODE) begin
               syn_in = req.syndrome;
               cls_in = '0; stb_in = '0; qb_in = '0;
               for (int i = 0; i < cpd_pkg::MaxClasses; i++) sums_in[i] = '0;
               state_in = cpd_pkg::ST_RD;
            end
         end
         // class table read issued; prob read next
         cpd_pkg::ST_RD: state_in = cpd_pkg::ST_MUL;
         cpd_pkg::ST_MUL: begin
            state_in = cpd_pkg::ST_ACC;
         end
         cpd_pkg::ST_ACC: begin
            // prob_rd valid now
            term_in = (qb_ff == '0) ? prob_rd : prod[2*PB-1:PB];
            if ({1'b0, qb_ff} + 4'd1 < nq_c) begin
               qb_in = qb_ff + 1'b1;
               state_in = cpd_pkg::ST_RD;
            end else begin
               qb_in = '0;
               sums_in[cls_ff] = sums_ff[cls_ff] +
                  SB'((qb_ff == '0) ? prob_rd : prod[2*PB-1:PB]);
               if ({1'b0, stb_ff} + 5'd1 < ns_c) begin
                  stb_in = stb_ff + 1'b1;
                  state_in = cpd_pkg::ST_RD;
               end else begin
                  stb_in = '0;
                  if ({1'b0, cls_ff} + 3'd1 < nc_c) begin
                     cls_in = cls_ff + 1'b1;
                     state_in = cpd_pkg::ST_RD;
                  end else begin
                     cls_in = '0;
                     state_in = cpd_pkg::ST_TOT;
                  end
               end
            end
         end
         cpd_pkg::ST_TOT: begin
            tot_in = '0;
            for (int i = 0; i < cpd_pkg::MaxClasses; i++)
               if (i < int'(nc_c)) tot_in = tot_in + (SB+2)'(sums_ff[i]);
            best_in = '0;
            state_in = cpd_pkg::ST_DIV;
         end
         cpd_pkg::ST_DIV: begin
            // quotient fits in PB+1 bits since num <= den
            rem_in = (SB+3)'(sums_ff[cls_ff]);
            quo_in = '0;
            step_in = '0;
            if (rem_in >= {1'b0, tot_ff}) begin
               rem_in = rem_in - {1'b0, tot_ff};
               quo_in = (PB+1)'(1);
            end
            state_in = (tot_ff == '0) ? cpd_pkg::ST_DEND : cpd_pkg::ST_DSTEP;
         end
         cpd_pkg::ST_DSTEP: begin
            rem_sh = {rem_ff[SB+1:0], 1'b0};
            quo_in = {quo_ff[PB-1:0], 1'b0};
            rem_in = rem_sh;
            if (rem_sh >= {1'b0, tot_ff}) begin
               rem_in = rem_sh - {1'b0, tot_ff};
               quo_in[0] = 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 6'(PB-1)) state_in = cpd_pkg::ST_DEND;
         end
         cpd_pkg::ST_DEND: begin
            probs_in[cls_ff] = (tot_ff == '0) ? '0 : (quo_ff[PB] ? '1 : quo_ff[PB-1:0]);
            if (probs_in[cls_ff] > probs_ff[best_ff] && cls_ff != '0) best_in = cls_ff;
            if ({1'b0, cls_ff} + 3'd1 < nc_c) begin
               cls_in = cls_ff + 1'b1;
               state_in = cpd_pkg::ST_DIV;
            end else begin
               cls_in = '0;
               rv_in = 1'b1;
               state_in = cpd_pkg::ST_OUT;
            end
         end
         cpd_pkg::ST_OUT: begin
            if (rsp.ready) begin
               if (last_out) begin
                  rv_in = 1'b0;
                  cls_in = '0;
                  state_in = cpd_pkg::ST_IDLE;
               end else begin
                  cls_in = cls_ff + 1'b1;
               end
            end
         end
         default: state_in = cpd_pkg::ST_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpd_pkg::ST_IDLE;
         nq_ff <= 4'd8; nc_ff <= 3'd4; ns_ff <= 5'd16;
         rv_ff <= 1'b0;
         cls_ff <= '0; stb_ff <= '0; qb_ff <= '0;
         best_ff <= '0;
      end else begin
         state_ff <= state_in;
         nq_ff <= nq_in; nc_ff <= nc_in; ns_ff <= ns_in;
         rv_ff <= rv_in;
         cls_ff <= cls_in; stb_ff <= stb_in; qb_ff <= qb_in;
         best_ff <= best_in;
      end
      syn_ff <= syn_in; term_ff <= term_in; tot_ff <= tot_in;
      rem_ff <= rem_in; quo_ff <= quo_in; step_ff <= step_in;
      sums_ff <= sums_in; probs_ff <= probs_in;
   end

   assign rsp.valid = rv_ff;
   assign rsp.class_index = cls_ff;
   assign rsp.class_prob = probs_ff[cls_ff];
   assign rsp.best_class = last_out ? best_ff : '0;
   assign rsp.zero_total = (tot_ff == '0);
   assign rsp.last = last_out;

   `CPD_ASSERT_IMP(a_no_req_busy, clock, reset, state_ff != cpd_pkg::ST_IDLE, !req.ready, "req ready while busy")
   `CPD_ASSERT_IMP(a_valid_out, clock, reset, rsp.valid, state_ff == cpd_pkg::ST_OUT, "rsp valid outside output")
   `CPD_ASSERT_NXT(a_last_idle, clock, reset, rsp.valid && rsp.ready && rsp.last, state_ff == cpd_pkg::ST_IDLE, "no idle after last")
endmodule
`default_nettype wire

>>> sim/tb_coset_probability_decoder_core.sv
// Self-checking testbench for coset_probability_decoder_core: table loads, decodes, checks.
// Depends on cpd_pkg and the channel interfaces in cpd_if.
`default_nettype none
module tb_coset_probability_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      cpd_pkg::op_type op;
      logic [2:0] qubit;
      logic [1:0] pauli;
      logic [31:0] prob_value;
      logic [1:0] logical_class;
      logic [3:0] stabilizer;
      logic [3:0] syndrome;
   } load_word_type;

   typedef struct {
      logic [1:0] class_index;
      logic [31:0] class_prob;
      logic [1:0] best_class;
      logic zero_total;
      logic last;
   } class_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cpd_req_if req_ch (clock);
   cpd_rsp_if rsp_ch (clock);
   cpd_csr_if csr_ch (clock);

   coset_probability_decoder_core uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   always #5 clock = ~clock;

   // predictor copy of the tables and counts
   logic [31:0] pred_prob [cpd_pkg::MaxQubits][4];
   logic [1:0] pred_pauli [cpd_pkg::MaxClasses][cpd_pkg::MaxStabilizers][16]
      [cpd_pkg::MaxQubits];
   logic [7:0] pred_qubits = 8'd8;
   logic [7:0] pred_classes = 8'd4;
   logic [7:0] pred_stabs = 8'd16;

   // generator view: which class table entries have been written
   bit class_entry_set [cpd_pkg::MaxClasses][cpd_pkg::MaxStabilizers][16]
      [cpd_pkg::MaxQubits];
   int gen_qubits = 8, gen_classes = 4, gen_stabs = 16;

   load_word_type pending_words[$];
   class_result_type expected_classes[$];
   int fail_count = 0;
   bit busy_gaps = 1'b1;

   function automatic int clamp_count(input int v, input int hi);
      if (v < 1) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // sum path products per class, normalize, queue one result per class
   function automatic void predict_decode(input logic [3:0] syn);
      int nq, nc, ns, best;
      logic [39:0] sums [cpd_pkg::MaxClasses];
      logic [79:0] total, num, quo;
      logic [63:0] wide;
      logic [31:0] term;
      logic [31:0] probs [cpd_pkg::MaxClasses];
      class_result_type r;
      nq = clamp_count(int'(pred_qubits[3:0]), cpd_pkg::MaxQubits);
      nc = clamp_count(int'(pred_classes[2:0]), cpd_pkg::MaxClasses);
      ns = clamp_count(int'(pred_stabs[4:0]), cpd_pkg::MaxStabilizers);
      total = '0;
      for (int l = 0; l < nc; l++) begin
         sums[l] = '0;
         for (int s = 0; s < ns; s++) begin
            term = pred_prob[0][pred_pauli[l][s][syn][0]];
            for (int q = 1; q < nq; q++) begin
               wide = {32'b0, term} * {32'b0, pred_prob[q][pred_pauli[l][s][syn][q]]};
               term = wide[63:32];
            end
            sums[l] = sums[l] + {8'b0, term};
         end
         total = total + {40'b0, sums[l]};
      end
      best = 0;
      for (int l = 0; l < nc; l++) begin
         if (total == 0) begin
            probs[l] = '0;
         end else begin
            num = {40'b0, sums[l]} << 32;
            quo = num / total;
            probs[l] = (quo > 80'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
         end
         if (probs[l] > probs[best]) best = l;
      end
      for (int l = 0; l < nc; l++) begin
         r.class_index = 2'(l);
         r.class_prob = probs[l];
         r.best_class = (l == nc - 1) ? 2'(best) : 2'd0;
         r.zero_total = (total == 0);
         r.last = (l == nc - 1);
         expected_classes.push_back(r);
      end
   endfunction

   // ---------------- request driver ----------------
   bit req_taken = 1'b0;
   int req_gap = 0;

   // record accepted words and update the predictor
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         req_taken = 1'b1;
         case (cpd_pkg::op_type'(req_ch.op))
            cpd_pkg::OP_PROB: pred_prob[req_ch.qubit][req_ch.pauli] = req_ch.prob_value;
            cpd_pkg::OP_CLASS: pred_pauli[req_ch.logical_class][req_ch.stabilizer]
               [req_ch.syndrome][req_ch.qubit] = req_ch.pauli;
            cpd_pkg::OP_DECODE: predict_decode(req_ch.syndrome);
            default: ;
         endcase
      end
      if (!reset && csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            cpd_pkg::REG_QUBITS: pred_qubits = csr_ch.data;
            cpd_pkg::REG_CLASSES: pred_classes = csr_ch.data;
            cpd_pkg::REG_STABS: pred_stabs = csr_ch.data;
            default: ;
         endcase
      end
   end

   // present the next word after its drawn gap
   always @(negedge clock) begin
      load_word_type w;
      if (!reset && (!req_ch.valid || req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0 || pending_words.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_ch.valid <= 1'b0;
         end else begin
            w = pending_words.pop_front();
            req_ch.op <= w.op;
            req_ch.qubit <= w.qubit;
            req_ch.pauli <= w.pauli;
            req_ch.prob_value <= w.prob_value;
            req_ch.logical_class <= w.logical_class;
            req_ch.stabilizer <= w.stabilizer;
            req_ch.syndrome <= w.syndrome;
            req_ch.valid <= 1'b1;
            req_gap = busy_gaps ? $urandom_range(0, 17) : 0;
         end
      end
   end

   // ---------------- response monitor ----------------
   bit rsp_taken = 1'b0;
   int rsp_stall = 0;

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      class_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_taken = 1'b1;
         if (expected_classes.size() == 0) begin
            $display("%0t: unexpected result class %0d prob %h", $time,
               rsp_ch.class_index, rsp_ch.class_prob);
            fail_count++;
         end else begin
            e = expected_classes.pop_front();
            if (rsp_ch.class_index !== e.class_index || rsp_ch.class_prob !== e.class_prob
                  || rsp_ch.best_class !== e.best_class
                  || rsp_ch.zero_total !== e.zero_total || rsp_ch.last !== e.last) begin
               $display("%0t: mismatch expected idx %0d prob %h best %0d zero %b last %b",
                  $time, e.class_index, e.class_prob, e.best_class, e.zero_total, e.last);
               $display("%0t:          actual   idx %0d prob %h best %0d zero %b last %b",
                  $time, rsp_ch.class_index, rsp_ch.class_prob, rsp_ch.best_class,
                  rsp_ch.zero_total, rsp_ch.last);
               fail_count++;
            end
         end
      end
   end

   // stall the result channel a drawn number of cycles per word
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_stall = busy_gaps ? $urandom_range(0, 17) : 0;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic add_word(input cpd_pkg::op_type op, input logic [2:0] qubit,
         input logic [1:0] pauli, input logic [31:0] pv, input logic [1:0] lc,
         input logic [3:0] st, input logic [3:0] syn);
      load_word_type w;
      w.op = op; w.qubit = qubit; w.pauli = pauli; w.prob_value = pv;
      w.logical_class = lc; w.stabilizer = st; w.syndrome = syn;
      if (op == cpd_pkg::OP_CLASS) class_entry_set[lc][st][syn][qubit] = 1'b1;
      pending_words.push_back(w);
   endtask

   // fill any class table entries a decode of this syndrome would read, then decode
   task automatic decode_filled(input logic [3:0] syn);
      for (int l = 0; l < gen_classes; l++)
         for (int s = 0; s < gen_stabs; s++)
            for (int q = 0; q < gen_qubits; q++)
               if (!class_entry_set[l][s][syn][q])
                  add_word(cpd_pkg::OP_CLASS, 3'(q), 2'($urandom_range(0, 3)), $urandom,
                     2'(l), 4'(s), syn);
      add_word(cpd_pkg::OP_DECODE, 3'($urandom), 2'($urandom), $urandom, 2'($urandom),
         4'($urandom), syn);
   endtask

   task automatic wait_idle();
      wait (pending_words.size() == 0 && !req_ch.valid && expected_classes.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_ch.index <= idx;
      csr_ch.data <= data;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_counts(input logic [7:0] nq, input logic [7:0] nc, input logic [7:0] ns);
      wait_idle();
      write_reg(cpd_pkg::REG_QUBITS, nq);
      write_reg(cpd_pkg::REG_CLASSES, nc);
      write_reg(cpd_pkg::REG_STABS, ns);
      gen_qubits = clamp_count(int'(nq[3:0]), cpd_pkg::MaxQubits);
      gen_classes = clamp_count(int'(nc[2:0]), cpd_pkg::MaxClasses);
      gen_stabs = clamp_count(int'(ns[4:0]), cpd_pkg::MaxStabilizers);
   endtask

   // random phase: fill-and-decode sequences mixed with loose loads and dead ops
   task automatic random_phase(input int words);
      int pick;
      busy_gaps = $urandom_range(0, 3) != 0;
      for (int i = 0; i < words; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            decode_filled(4'($urandom));
         end else if (pick < 7) begin
            add_word(cpd_pkg::OP_PROB, 3'($urandom), 2'($urandom),
               ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom,
               2'($urandom), 4'($urandom), 4'($urandom));
         end else if (pick < 9) begin
            add_word(cpd_pkg::OP_CLASS, 3'($urandom), 2'($urandom), $urandom,
               2'($urandom), 4'($urandom), 4'($urandom));
         end else begin
            add_word(cpd_pkg::OP_NONE, 3'($urandom), 2'($urandom), $urandom,
               2'($urandom), 4'($urandom), 4'($urandom));
         end
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.op = cpd_pkg::OP_NONE;
      req_ch.qubit = '0;
      req_ch.pauli = '0;
      req_ch.prob_value = '0;
      req_ch.logical_class = '0;
      req_ch.stabilizer = '0;
      req_ch.syndrome = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = cpd_pkg::REG_QUBITS;
      csr_ch.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // load every probability entry so later decodes never read an unset one
      for (int q = 0; q < cpd_pkg::MaxQubits; q++)
         for (int p = 0; p < 4; p++)
            add_word(cpd_pkg::OP_PROB, 3'(q), 2'(p), $urandom | 32'h0100_0000,
               2'd0, 4'd0, 4'd0);

      // one qubit, two classes, one stabilizer; a certain class saturates, then a tie picks the first class
      set_counts(8'd1, 8'd2, 8'd1);
      add_word(cpd_pkg::OP_PROB, 3'd0, 2'd1, 32'h0000_0000, 2'd0, 4'd0, 4'd0);
      add_word(cpd_pkg::OP_CLASS, 3'd0, 2'd0, 32'd0, 2'd0, 4'd0, 4'd15);
      add_word(cpd_pkg::OP_CLASS, 3'd0, 2'd1, 32'd0, 2'd1, 4'd0, 4'd15);
      add_word(cpd_pkg::OP_DECODE, 3'd7, 2'd3, 32'hFFFF_FFFF, 2'd3, 4'd15, 4'd15);
      add_word(cpd_pkg::OP_CLASS, 3'd0, 2'd0, 32'd0, 2'd1, 4'd0, 4'd15);
      add_word(cpd_pkg::OP_PROB, 3'd0, 2'd0, 32'hFFFF_FFFF, 2'd0, 4'd0, 4'd0);
      add_word(cpd_pkg::OP_DECODE, 3'd0, 2'd0, 32'd0, 2'd0, 4'd0, 4'd15);
      // zero total: every path probability zero
      add_word(cpd_pkg::OP_PROB, 3'd0, 2'd0, 32'h0000_0000, 2'd0, 4'd0, 4'd0);
      add_word(cpd_pkg::OP_DECODE, 3'd0, 2'd0, 32'd0, 2'd0, 4'd0, 4'd15);
      add_word(cpd_pkg::OP_NONE, 3'd7, 2'd3, 32'hFFFF_FFFF, 2'd3, 4'd15, 4'd15);
      add_word(cpd_pkg::OP_PROB, 3'd0, 2'd0, 32'h8000_0000, 2'd0, 4'd0, 4'd0);

      // each count too large saturates to its maximum, one count at a time
      set_counts(8'd15, 8'd1, 8'd1);
      decode_filled(4'd3);
      set_counts(8'd1, 8'd7, 8'd1);
      decode_filled(4'd15);
      set_counts(8'd1, 8'd1, 8'd31);
      decode_filled(4'd15);

      // zero counts act as one, then a small mixed size
      set_counts(8'd0, 8'hF8, 8'd0);
      random_phase(10);
      set_counts(8'hF2, 8'd2, 8'd1);
      random_phase(8);

      wait_idle();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hard stop on a hang
   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
